// ===== src/rvcx_pkg.sv =====
`default_nettype none

package rvcx_pkg;

  localparam int PARCEL_W = 16;
  localparam int WORD_W   = 32;

  // RV32I major opcodes used by the expansion.
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LUI    = 7'h37;

  localparam logic [WORD_W-1:0] WORD_EBREAK = 32'h0010_0073;
  localparam logic [WORD_W-1:0] WORD_NOP    = 32'h0000_0013;

  // Quadrant codes in parcel bits 1:0.
  localparam logic [1:0] QUAD_0    = 2'b00;
  localparam logic [1:0] QUAD_1    = 2'b01;
  localparam logic [1:0] QUAD_2    = 2'b10;
  localparam logic [1:0] QUAD_FULL = 2'b11;

  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_SLL  = 3'b001;
  localparam logic [2:0] F3_LW   = 3'b010;
  localparam logic [2:0] F3_XOR  = 3'b100;
  localparam logic [2:0] F3_SR   = 3'b101;
  localparam logic [2:0] F3_OR   = 3'b110;
  localparam logic [2:0] F3_AND  = 3'b111;
  localparam logic [2:0] F3_BEQ  = 3'b000;
  localparam logic [2:0] F3_BNE  = 3'b001;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;
  localparam logic [4:0] REG_SP   = 5'd2;

  typedef struct packed {
    logic              is_compressed;
    logic              illegal;
    logic [WORD_W-1:0] word;
  } exp_result_t;

  function automatic exp_result_t expand(input logic [PARCEL_W-1:0] p);
    exp_result_t res;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [4:0]  rs2;
    logic [4:0]  rdp;
    logic [4:0]  rs1p;
    logic        b12;
    logic [11:0] imm6;
    logic        imm6_zero;
    logic [9:0]  joff;
    logic [11:0] imm12;
    logic [2:0]  f3_alu;
    logic [WORD_W-1:0] w;
    logic        bad;
    f3        = p[15:13];
    rd        = p[11:7];
    rs2       = p[6:2];
    rdp       = {2'b01, p[4:2]};
    rs1p      = {2'b01, p[9:7]};
    b12       = p[12];
    imm6      = {{6{p[12]}}, p[12], p[6:2]};
    imm6_zero = !p[12] && (p[6:2] == 5'd0);
    joff      = {p[8], p[10:9], p[6], p[7], p[2], p[11], p[5:3]};
    imm12     = '0;
    f3_alu    = F3_ADD;
    w         = '0;
    bad       = 1'b0;
    case (p[1:0])
      QUAD_0: begin
        case (f3)
          3'd0: begin
            // c.addi4spn
            imm12 = {2'b00, p[10:7], p[12:11], p[5], p[6], 2'b00};
            if (imm12 == 12'd0) begin
              bad = 1'b1;
            end else begin
              w = {imm12, REG_SP, F3_ADD, rdp, OPC_OPIMM};
            end
          end
          3'd2: begin
            w = {5'b0, p[5], p[12:10], p[6], 2'b00, rs1p, F3_LW, rdp, OPC_LOAD};
          end
          3'd6: begin
            w = {5'b0, p[5], p[12], rdp, rs1p, F3_LW, p[11:10], p[6], 2'b00, OPC_STORE};
          end
          default: bad = 1'b1;
        endcase
      end
      QUAD_1: begin
        case (f3)
          3'd0: begin
            if (rd == REG_ZERO) begin
              w = WORD_NOP;
            end else if (imm6_zero) begin
              bad = 1'b1;
            end else begin
              w = {imm6, rd, F3_ADD, rd, OPC_OPIMM};
            end
          end
          3'd1: w = {b12, joff, b12, {8{b12}}, REG_RA, OPC_JAL};
          3'd2: begin
            if (rd == REG_ZERO) begin
              w = WORD_NOP;
            end else begin
              w = {imm6, REG_ZERO, F3_ADD, rd, OPC_OPIMM};
            end
          end
          3'd3: begin
            if (rd == REG_ZERO) begin
              w = WORD_NOP;
            end else if (imm6_zero) begin
              bad = 1'b1;
            end else if (rd == REG_SP) begin
              // c.addi16sp
              imm12 = {{3{b12}}, p[4:3], p[5], p[2], p[6], 4'b0000};
              w = {imm12, REG_SP, F3_ADD, REG_SP, OPC_OPIMM};
            end else begin
              w = {{14{b12}}, b12, p[6:2], rd, OPC_LUI};
            end
          end
          3'd4: begin
            case (p[11:10])
              2'd0, 2'd1: begin
                if (b12) begin
                  bad = 1'b1;
                end else begin
                  w = {1'b0, p[10], 5'b0, rs2, rs1p, F3_SR, rs1p, OPC_OPIMM};
                end
              end
              2'd2: w = {imm6, rs1p, F3_AND, rs1p, OPC_OPIMM};
              default: begin
                case (p[6:5])
                  2'd0:    f3_alu = F3_ADD;
                  2'd1:    f3_alu = F3_XOR;
                  2'd2:    f3_alu = F3_OR;
                  default: f3_alu = F3_AND;
                endcase
                if (b12) begin
                  bad = 1'b1;
                end else begin
                  w = {1'b0, (p[6:5] == 2'd0), 5'b0, rdp, rs1p, f3_alu, rs1p, OPC_OP};
                end
              end
            endcase
          end
          3'd5: w = {b12, joff, b12, {8{b12}}, REG_ZERO, OPC_JAL};
          3'd6: begin
            w = {b12, {3{b12}}, p[6:5], p[2], REG_ZERO, rs1p, F3_BEQ,
                 p[11:10], p[4:3], b12, OPC_BRANCH};
          end
          default: begin
            w = {b12, {3{b12}}, p[6:5], p[2], REG_ZERO, rs1p, F3_BNE,
                 p[11:10], p[4:3], b12, OPC_BRANCH};
          end
        endcase
      end
      QUAD_2: begin
        case (f3)
          3'd0: begin
            if (b12) begin
              bad = 1'b1;
            end else begin
              w = {7'b0, rs2, rd, F3_SLL, rd, OPC_OPIMM};
            end
          end
          3'd2: begin
            if (rd == REG_ZERO) begin
              bad = 1'b1;
            end else begin
              w = {4'b0, p[3:2], b12, p[6:4], 2'b00, REG_SP, F3_LW, rd, OPC_LOAD};
            end
          end
          3'd4: begin
            if (!b12) begin
              if (rs2 == REG_ZERO) begin
                if (rd == REG_ZERO) begin
                  bad = 1'b1;
                end else begin
                  w = {12'd0, rd, F3_ADD, REG_ZERO, OPC_JALR};
                end
              end else if (rd == REG_ZERO) begin
                w = WORD_NOP;
              end else begin
                w = {7'b0, rs2, REG_ZERO, F3_ADD, rd, OPC_OP};
              end
            end else begin
              if (rs2 == REG_ZERO) begin
                if (rd == REG_ZERO) begin
                  w = WORD_EBREAK;
                end else begin
                  w = {12'd0, rd, F3_ADD, REG_RA, OPC_JALR};
                end
              end else if (rd == REG_ZERO) begin
                w = WORD_NOP;
              end else begin
                w = {7'b0, rs2, rd, F3_ADD, rd, OPC_OP};
              end
            end
          end
          3'd6: begin
            w = {4'b0, p[8:7], b12, rs2, REG_SP, F3_LW, p[11:9], 2'b00, OPC_STORE};
          end
          default: bad = 1'b1;
        endcase
      end
      default: begin
        w   = '0;
        bad = 1'b0;
      end
    endcase
    res.is_compressed = (p[1:0] != QUAD_FULL);
    res.illegal       = res.is_compressed && bad;
    res.word          = (res.is_compressed && !bad) ? w : '0;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/rv32c_instruction_expander_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   parcel[15:0]
// result    out        out_valid / out_ready is_compressed, expanded_word[31:0], illegal
//
// Each request yields one result, held in the parcel register and then in the
// result register; one request can be accepted every cycle while the result
// side does not stall. The expansion is a single pass of decode logic between them.
// Synchronous reset clears both valid flags; payload registers are not reset.
// A stalled result holds the result register, and the parcel register still
// takes a new request as long as it is empty or moving forward.
module rv32c_instruction_expander_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [rvcx_pkg::PARCEL_W-1:0] parcel,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              is_compressed,
  output logic [rvcx_pkg::WORD_W-1:0]       expanded_word,
  output logic                              illegal
);
  import rvcx_pkg::*;

  logic                s1_valid;
  logic [PARCEL_W-1:0] s1_parcel;
  logic                s1_adv;
  exp_result_t         s1_res;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign s1_res   = expand(s1_parcel);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_parcel <= parcel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      is_compressed <= s1_res.is_compressed;
      expanded_word <= s1_res.word;
      illegal       <= s1_res.illegal;
    end
  end

endmodule

`default_nettype wire

// ===== src/rvcx_checker.sv =====
`default_nettype none

module rvcx_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         is_compressed,
  input wire logic [rvcx_pkg::WORD_W-1:0]  expanded_word,
  input wire logic                         illegal
);
  import rvcx_pkg::*;

  // A reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // An illegal or uncompressed parcel carries an all-zero word.
  a_illegal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (illegal || !is_compressed) |-> expanded_word == '0)
    else $error("nonzero word on illegal or uncompressed result");

  a_full_not_illegal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_compressed |-> !illegal)
    else $error("uncompressed parcel flagged illegal");

  // Every legal expansion is a 32-bit encoding.
  a_legal_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_compressed && !illegal |-> expanded_word[1:0] == QUAD_FULL)
    else $error("expanded word is not a 32-bit encoding");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(expanded_word)
      && $stable(illegal) && $stable(is_compressed))
    else $error("stalled result changed");

endmodule

bind rv32c_instruction_expander_unit rvcx_checker u_rvcx_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .is_compressed (is_compressed),
  .expanded_word (expanded_word),
  .illegal       (illegal)
);

`default_nettype wire

// ===== bench/tb_rv32c_instruction_expander_unit.sv =====
`timescale 1ns / 100ps

module tb_rv32c_instruction_expander_unit;
  import rvcx_pkg::*;

  // Compressed funct3 codes, per quadrant.
  localparam logic [2:0] C0_ADDI4SPN  = 3'd0;
  localparam logic [2:0] C0_LW        = 3'd2;
  localparam logic [2:0] C0_SW        = 3'd6;
  localparam logic [2:0] C1_ADDI      = 3'd0;
  localparam logic [2:0] C1_JAL       = 3'd1;
  localparam logic [2:0] C1_LI        = 3'd2;
  localparam logic [2:0] C1_LUI       = 3'd3;
  localparam logic [2:0] C1_ARITH     = 3'd4;
  localparam logic [2:0] C1_J         = 3'd5;
  localparam logic [2:0] C1_BEQZ      = 3'd6;
  localparam logic [2:0] C2_SLLI      = 3'd0;
  localparam logic [2:0] C2_LWSP      = 3'd2;
  localparam logic [2:0] C2_JR_MV_ADD = 3'd4;
  localparam logic [2:0] C2_SWSP      = 3'd6;

  // Sub-codes of the quadrant 1 arithmetic group.
  localparam logic [1:0] ARITH_SRLI = 2'd0;
  localparam logic [1:0] ARITH_SRAI = 2'd1;
  localparam logic [1:0] ARITH_ANDI = 2'd2;
  localparam logic [1:0] RR_SUB     = 2'd0;
  localparam logic [1:0] RR_XOR     = 2'd1;
  localparam logic [1:0] RR_OR      = 2'd2;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam int RANDOM_ITEMS = 1700;
  localparam int CALM_FIRST   = 900;
  localparam int CALM_LAST    = 1200;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic        is_c;
    logic [31:0] word;
    logic        ill;
  } expansion_t;

  typedef struct packed {
    logic [15:0] parcel;
    expansion_t  exp;
  } pending_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_ILLEGAL, ROW_FULL, ROW_WORD} row_kind_t;

  typedef struct packed {
    logic [15:0] parcel;
    row_kind_t   kind;
    logic [31:0] word;
  } dir_row_t;

  localparam int DIR_N = 44;
  localparam dir_row_t DIRECTED [DIR_N] = '{
    '{16'h0000, ROW_ILLEGAL, 32'h0},
    '{16'hFFFF, ROW_FULL,    32'h0},
    '{16'h1FFC, ROW_PREDICT, 32'h0},
    '{16'h5FFC, ROW_PREDICT, 32'h0},
    '{16'hDFFC, ROW_PREDICT, 32'h0},
    '{16'hE000, ROW_ILLEGAL, 32'h0},
    '{16'h0001, ROW_WORD,    WORD_NOP},
    '{16'h0005, ROW_WORD,    WORD_NOP},
    '{16'h0081, ROW_ILLEGAL, 32'h0},
    '{16'h1FFD, ROW_PREDICT, 32'h0},
    '{16'h3FFD, ROW_PREDICT, 32'h0},
    '{16'h4001, ROW_WORD,    WORD_NOP},
    '{16'h5FFD, ROW_PREDICT, 32'h0},
    '{16'h6005, ROW_WORD,    WORD_NOP},
    '{16'h6181, ROW_ILLEGAL, 32'h0},
    '{16'h6101, ROW_ILLEGAL, 32'h0},
    '{16'h717D, ROW_PREDICT, 32'h0},
    '{16'h7FFD, ROW_PREDICT, 32'h0},
    '{16'h9001, ROW_ILLEGAL, 32'h0},
    '{16'h8081, ROW_PREDICT, 32'h0},
    '{16'h87FD, ROW_PREDICT, 32'h0},
    '{16'h9BFD, ROW_PREDICT, 32'h0},
    '{16'h8F9D, ROW_PREDICT, 32'h0},
    '{16'h8FBD, ROW_PREDICT, 32'h0},
    '{16'h8FDD, ROW_PREDICT, 32'h0},
    '{16'h8FFD, ROW_PREDICT, 32'h0},
    '{16'h9C85, ROW_ILLEGAL, 32'h0},
    '{16'hBFFD, ROW_PREDICT, 32'h0},
    '{16'hDFFD, ROW_PREDICT, 32'h0},
    '{16'hFFFD, ROW_PREDICT, 32'h0},
    '{16'h0FFE, ROW_PREDICT, 32'h0},
    '{16'h1086, ROW_ILLEGAL, 32'h0},
    '{16'h5FFE, ROW_PREDICT, 32'h0},
    '{16'h4002, ROW_ILLEGAL, 32'h0},
    '{16'hDFFE, ROW_PREDICT, 32'h0},
    '{16'h8F82, ROW_PREDICT, 32'h0},
    '{16'h8002, ROW_ILLEGAL, 32'h0},
    '{16'h8FFE, ROW_PREDICT, 32'h0},
    '{16'h8006, ROW_WORD,    WORD_NOP},
    '{16'h9002, ROW_WORD,    WORD_EBREAK},
    '{16'h9F82, ROW_PREDICT, 32'h0},
    '{16'h9FFE, ROW_PREDICT, 32'h0},
    '{16'h9006, ROW_WORD,    WORD_NOP},
    '{16'hA002, ROW_ILLEGAL, 32'h0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] parcel;
  logic        out_valid;
  logic        out_ready;
  logic        is_compressed;
  logic [31:0] expanded_word;
  logic        illegal;

  pending_t pending_expansions [$];
  pending_t oldest;
  logic     calm = 1'b0;
  logic     hold_done = 1'b0;
  int       granted = 0;
  int       results_seen = 0;
  int       illegal_seen = 0;
  int       plain_seen = 0;
  int       mismatches = 0;
  int       cycle_count = 0;

  rv32c_instruction_expander_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .parcel        (parcel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_compressed (is_compressed),
    .expanded_word (expanded_word),
    .illegal       (illegal)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] i_type(input logic [11:0] imm, input logic [4:0] rs1,
                                         input logic [2:0] f3, input logic [4:0] rd,
                                         input logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] r_type(input logic [6:0] f7, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3,
                                         input logic [4:0] rd, input logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] s_type(input logic [11:0] imm, input logic [4:0] rs2,
                                         input logic [4:0] rs1);
    return {imm[11:5], rs2, rs1, F3_LW, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] b_type(input logic [12:0] imm, input logic [4:0] rs1,
                                         input logic [2:0] f3);
    return {imm[12], imm[10:5], REG_ZERO, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] j_type(input logic [20:0] imm, input logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic expansion_t predict_expansion(input logic [15:0] p);
    expansion_t  res;
    logic [31:0] w;
    logic        bad;
    logic [2:0]  op;
    logic        b12;
    logic [4:0]  rd;
    logic [4:0]  rs2;
    logic [4:0]  rdp;
    logic [4:0]  rs1p;
    logic [31:0] imm6;
    logic        imm6_zero;
    logic [11:0] mem_off;
    logic [11:0] imm12;
    logic [20:0] jump_off;
    logic [12:0] branch_off;
    logic [2:0]  alu_f3;
    op         = p[15:13];
    b12        = p[12];
    rd         = p[11:7];
    rs2        = p[6:2];
    rdp        = {2'b01, p[4:2]};
    rs1p       = {2'b01, p[9:7]};
    imm6       = {{26{b12}}, b12, p[6:2]};
    imm6_zero  = ({b12, p[6:2]} == 6'd0);
    mem_off    = {5'd0, p[5], p[12:10], p[6], 2'b00};
    jump_off   = {{10{b12}}, p[8], p[10:9], p[6], p[7], p[2], p[11], p[5:3], 1'b0};
    branch_off = {{5{b12}}, p[6:5], p[2], p[11:10], p[4:3], 1'b0};
    imm12      = '0;
    alu_f3     = F3_ADD;
    w          = '0;
    bad        = 1'b0;
    case (p[1:0])
      QUAD_0: begin
        case (op)
          C0_ADDI4SPN: begin
            imm12 = {2'b00, p[10:7], p[12:11], p[5], p[6], 2'b00};
            if (imm12 == 12'd0) bad = 1'b1;
            else w = i_type(imm12, REG_SP, F3_ADD, rdp, OPC_OPIMM);
          end
          C0_LW:   w = i_type(mem_off, rs1p, F3_LW, rdp, OPC_LOAD);
          C0_SW:   w = s_type(mem_off, rdp, rs1p);
          default: bad = 1'b1;
        endcase
      end
      QUAD_1: begin
        case (op)
          C1_ADDI: begin
            if (rd == REG_ZERO) w = WORD_NOP;
            else if (imm6_zero) bad = 1'b1;
            else w = i_type(imm6[11:0], rd, F3_ADD, rd, OPC_OPIMM);
          end
          C1_JAL: w = j_type(jump_off, REG_RA);
          C1_LI: begin
            if (rd == REG_ZERO) w = WORD_NOP;
            else w = i_type(imm6[11:0], REG_ZERO, F3_ADD, rd, OPC_OPIMM);
          end
          C1_LUI: begin
            if (rd == REG_ZERO) begin
              w = WORD_NOP;
            end else if (imm6_zero) begin
              bad = 1'b1;
            end else if (rd == REG_SP) begin
              // Stack pointer adjust, scaled by 16.
              imm12 = {{3{b12}}, p[4:3], p[5], p[2], p[6], 4'b0000};
              w = i_type(imm12, REG_SP, F3_ADD, REG_SP, OPC_OPIMM);
            end else begin
              w = {imm6[19:0], rd, OPC_LUI};
            end
          end
          C1_ARITH: begin
            case (p[11:10])
              ARITH_SRLI, ARITH_SRAI: begin
                if (b12) bad = 1'b1;
                else w = r_type(p[10] ? F7_ALT : F7_BASE, rs2, rs1p, F3_SR, rs1p, OPC_OPIMM);
              end
              ARITH_ANDI: w = i_type(imm6[11:0], rs1p, F3_AND, rs1p, OPC_OPIMM);
              default: begin
                case (p[6:5])
                  RR_SUB:  alu_f3 = F3_ADD;
                  RR_XOR:  alu_f3 = F3_XOR;
                  RR_OR:   alu_f3 = F3_OR;
                  default: alu_f3 = F3_AND;
                endcase
                if (b12) bad = 1'b1;
                else w = r_type((p[6:5] == RR_SUB) ? F7_ALT : F7_BASE, rdp, rs1p, alu_f3,
                                rs1p, OPC_OP);
              end
            endcase
          end
          C1_J:    w = j_type(jump_off, REG_ZERO);
          C1_BEQZ: w = b_type(branch_off, rs1p, F3_BEQ);
          default: w = b_type(branch_off, rs1p, F3_BNE);
        endcase
      end
      QUAD_2: begin
        case (op)
          C2_SLLI: begin
            if (b12) bad = 1'b1;
            else w = r_type(F7_BASE, rs2, rd, F3_SLL, rd, OPC_OPIMM);
          end
          C2_LWSP: begin
            if (rd == REG_ZERO) bad = 1'b1;
            else w = i_type({4'd0, p[3:2], b12, p[6:4], 2'b00}, REG_SP, F3_LW, rd, OPC_LOAD);
          end
          C2_JR_MV_ADD: begin
            if (rs2 == REG_ZERO) begin
              if (rd != REG_ZERO) w = i_type(12'd0, rd, F3_ADD, b12 ? REG_RA : REG_ZERO, OPC_JALR);
              else if (b12) w = WORD_EBREAK;
              else bad = 1'b1;
            end else if (rd == REG_ZERO) begin
              w = WORD_NOP;
            end else begin
              w = r_type(F7_BASE, rs2, b12 ? rd : REG_ZERO, F3_ADD, rd, OPC_OP);
            end
          end
          C2_SWSP: w = s_type({4'd0, p[8:7], p[12:9], 2'b00}, rs2, REG_SP);
          default: bad = 1'b1;
        endcase
      end
      default: ;
    endcase
    if (p[1:0] == QUAD_FULL) begin
      res = '0;
    end else begin
      res.is_c = 1'b1;
      res.word = bad ? 32'h0 : w;
      res.ill  = bad;
    end
    return res;
  endfunction

  // Offers one request, with an occasional gap before it, and records the
  // expectation once the handshake is certain to complete at the next edge.
  task automatic offer_parcel(input logic [15:0] p, input expansion_t want);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    parcel   <= p;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    pending_expansions.push_back('{parcel: p, exp: want});
    granted++;
    @(posedge clk);
  endtask

  initial begin
    dir_row_t    row;
    expansion_t  want;
    logic [15:0] p;
    in_valid = 1'b0;
    parcel   = '0;
    rst      = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      row = DIRECTED[i];
      case (row.kind)
        ROW_ILLEGAL: want = '{is_c: 1'b1, word: 32'h0, ill: 1'b1};
        ROW_FULL:    want = '{is_c: 1'b0, word: 32'h0, ill: 1'b0};
        ROW_WORD:    want = '{is_c: 1'b1, word: row.word, ill: 1'b0};
        default:     want = predict_expansion(row.parcel);
      endcase
      offer_parcel(row.parcel, want);
    end

    // Mostly compressed parcels, with register and immediate fields cleared
    // now and then so that hints and illegal forms come up often.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      p = 16'($urandom);
      if ($urandom_range(0, 9) != 0) begin
        p[1:0] = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 15) p[11:7] = REG_ZERO;
        if ($urandom_range(0, 99) < 15) p[6:2] = REG_ZERO;
        if ($urandom_range(0, 99) < 10) p[12] = 1'b0;
      end
      offer_parcel(p, predict_expansion(p));
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending_expansions.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Expanded %0d parcels across all quadrants: %0d illegal, %0d uncompressed.",
             results_seen, illegal_seen, plain_seen);
    $display("Directed edge encodings, random parcels, idle gaps and a long output stall.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!hold_done && granted >= HOLD_AT) begin
        // Long stall on the result side so the pipeline fills and backs up.
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 27);
    end
  end

  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (illegal === 1'b1) illegal_seen++;
      if (is_compressed === 1'b0) plain_seen++;
      if (pending_expansions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result with no request pending: is_compressed=%0b word=%08h illegal=%0b",
                   is_compressed, expanded_word, illegal);
      end else begin
        oldest = pending_expansions.pop_front();
        if (is_compressed !== oldest.exp.is_c || expanded_word !== oldest.exp.word ||
            illegal !== oldest.exp.ill) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Parcel %04h: expected c=%0b w=%08h ill=%0b, got c=%0b w=%08h ill=%0b",
                     oldest.parcel, oldest.exp.is_c, oldest.exp.word, oldest.exp.ill,
                     is_compressed, expanded_word, illegal);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_expansions.size());
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
